// ===== src/amc_pkg.sv =====
// amc_pkg: shared types and constants of the multi-pattern string matcher
// used by amc_engine, amc_rsp_reg and multi_pattern_string_matcher
package amc_pkg;

   localparam int ALPHABET_SIZE = 64;
   localparam int SYM_W         = 6;
   localparam int MAX_NODES     = 256;
   localparam int NODE_W        = 8;
   localparam int NCNT_W        = NODE_W + 1;
   localparam int MAX_PATTERNS  = 16;
   localparam int PAT_W         = 4;
   localparam int PCNT_W        = PAT_W + 1;
   localparam int RESULT_CAP    = 16;
   localparam int RCNT_W        = 5;
   localparam int LEN_W         = 8;
   localparam int POS_W         = 32;
   localparam int NUM_W         = 5;
   localparam int KIND_W        = 2;
   localparam int CHILD_AW      = NODE_W + SYM_W;
   localparam int CHILD_DEPTH   = MAX_NODES * ALPHABET_SIZE;

   localparam logic ACT_SCAN = 1'b1;

   localparam logic [KIND_W-1:0] KIND_MATCH     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NODE_FULL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SLOT_FULL = 2'd2;

   typedef struct packed {
      logic             action;
      logic [SYM_W-1:0] symbol;
      logic             pattern_end;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  start_position;
      logic [NUM_W-1:0]  pattern_number;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic    push;
      rsp_type data;
   } push_type;

   // one pending suffix-link computation
   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              walk;
      logic [NODE_W-1:0] cur;
   } frame_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_B_RD, ST_B_DEC, ST_S_RD, ST_S_DEC,
      ST_L_REQ, ST_L_DAT, ST_E_EVAL, ST_E_PAR, ST_E_PLNK, ST_E_SYM,
      ST_E_CHD, ST_E_XLNK, ST_E_POP, ST_E_RES, ST_M_TEST, ST_M_PAT, ST_M_END
   } st_type;

   typedef enum logic {RET_SCAN, RET_MATCH} ret_type;

endpackage

// ===== src/amc_engine.sv =====
// amc_engine: trie memories and the sequencer that builds, steps and walks the automaton
// depends on amc_pkg
module amc_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  amc_pkg::req_type  req_data,
   output logic              ready,
   input  logic              out_free,
   output amc_pkg::push_type push
);

   // memories
   logic [amc_pkg::NODE_W-1:0] child_mem [amc_pkg::CHILD_DEPTH];
   logic [amc_pkg::NODE_W-1:0] parent_mem [amc_pkg::MAX_NODES];
   logic [amc_pkg::SYM_W-1:0]  sym_mem [amc_pkg::MAX_NODES];
   logic [amc_pkg::NODE_W-1:0] link_mem [amc_pkg::MAX_NODES];
   logic [amc_pkg::PAT_W-1:0]  tpat_mem [amc_pkg::MAX_NODES];
   amc_pkg::frame_type         stack_mem [amc_pkg::MAX_NODES];

   logic [amc_pkg::NODE_W-1:0] child_q, parent_q, link_q;
   logic [amc_pkg::SYM_W-1:0]  sym_q;
   logic [amc_pkg::PAT_W-1:0]  tpat_q;
   amc_pkg::frame_type         stack_q;

   logic [amc_pkg::CHILD_AW-1:0] child_raddr, child_waddr;
   logic                         child_we;
   logic [amc_pkg::NODE_W-1:0]   child_wdata;
   logic                         alloc_we;
   logic [amc_pkg::NODE_W-1:0]   alloc_node;
   logic [amc_pkg::NODE_W-1:0]   link_raddr;
   logic                         link_we;
   logic [amc_pkg::NODE_W-1:0]   link_wdata;
   logic                         tpat_we;
   logic [amc_pkg::NODE_W-1:0]   stack_raddr;
   logic                         stack_we;

   // registers
   amc_pkg::st_type              state_ff, state_in;
   logic [amc_pkg::SYM_W-1:0]    sym_ff, sym_in;
   logic                         fin_ff, fin_in;
   logic [amc_pkg::NCNT_W-1:0]   ncount_ff, ncount_in;
   logic [amc_pkg::PCNT_W-1:0]   pcount_ff, pcount_in;
   logic [amc_pkg::NODE_W-1:0]   bnode_ff, bnode_in;
   logic [amc_pkg::LEN_W-1:0]    blen_ff, blen_in;
   logic                         bfault_ff, bfault_in;
   logic [amc_pkg::NODE_W-1:0]   snode_ff, snode_in;
   logic [amc_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [amc_pkg::MAX_NODES-1:0] known_ff, known_in;
   logic [amc_pkg::MAX_NODES-1:0] mark_ff, mark_in;
   logic [amc_pkg::LEN_W-1:0]    plen_ff [amc_pkg::MAX_PATTERNS];
   logic                         plen_we;
   logic [amc_pkg::LEN_W-1:0]    plen_wdata;
   amc_pkg::frame_type           f_ff, f_in;
   logic [amc_pkg::NODE_W-1:0]   sp_ff, sp_in;
   logic [amc_pkg::NODE_W-1:0]   tgt_ff, tgt_in;
   amc_pkg::ret_type             ret_ff, ret_in;
   logic [amc_pkg::NODE_W-1:0]   x_ff, x_in;
   logic [amc_pkg::NODE_W-1:0]   u_ff, u_in;
   logic [amc_pkg::RCNT_W-1:0]   cnt_ff, cnt_in;
   logic                         held_valid_ff, held_valid_in;
   amc_pkg::rsp_type             held_ff, held_in;
   logic [amc_pkg::CHILD_AW-1:0] clr_ff, clr_in;

   logic [amc_pkg::NODE_W-1:0] new_child;
   logic                       slot_full;
   logic [amc_pkg::LEN_W-1:0]  len_next;
   amc_pkg::rsp_type           match_rsp;

   assign ready      = (state_ff == amc_pkg::ST_IDLE);
   assign new_child  = (child_q != '0) ? child_q : ncount_ff[amc_pkg::NODE_W-1:0];
   assign slot_full  = pcount_ff[amc_pkg::PCNT_W-1];
   assign len_next   = blen_ff + 1'b1;
   assign alloc_node = ncount_ff[amc_pkg::NODE_W-1:0];
   assign plen_wdata = len_next;

   always_comb begin
      match_rsp.kind           = amc_pkg::KIND_MATCH;
      match_rsp.start_position = pos_ff - {{(amc_pkg::POS_W-amc_pkg::LEN_W){1'b0}},
                                 plen_ff[tpat_q]} + 1'b1;
      match_rsp.pattern_number = {1'b0, tpat_q} + 1'b1;
      match_rsp.last           = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= amc_pkg::ST_CLEAR;
         ncount_ff     <= amc_pkg::NCNT_W'(1);
         pcount_ff     <= '0;
         bnode_ff      <= '0;
         blen_ff       <= '0;
         bfault_ff     <= 1'b0;
         snode_ff      <= '0;
         pos_ff        <= '0;
         known_ff      <= '0;
         mark_ff       <= '0;
         sp_ff         <= '0;
         cnt_ff        <= '0;
         held_valid_ff <= 1'b0;
         clr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         ncount_ff     <= ncount_in;
         pcount_ff     <= pcount_in;
         bnode_ff      <= bnode_in;
         blen_ff       <= blen_in;
         bfault_ff     <= bfault_in;
         snode_ff      <= snode_in;
         pos_ff        <= pos_in;
         known_ff      <= known_in;
         mark_ff       <= mark_in;
         sp_ff         <= sp_in;
         cnt_ff        <= cnt_in;
         held_valid_ff <= held_valid_in;
         clr_ff        <= clr_in;
      end
      sym_ff  <= sym_in;
      fin_ff  <= fin_in;
      f_ff    <= f_in;
      tgt_ff  <= tgt_in;
      ret_ff  <= ret_in;
      x_ff    <= x_in;
      u_ff    <= u_in;
      held_ff <= held_in;
      if (plen_we) begin
         plen_ff[pcount_ff[amc_pkg::PAT_W-1:0]] <= plen_wdata;
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_waddr] <= child_wdata;
      end
      child_q <= child_mem[child_raddr];
   end

   always_ff @(posedge clock) begin
      if (alloc_we) begin
         parent_mem[alloc_node] <= bnode_ff;
         sym_mem[alloc_node]    <= sym_ff;
      end
      parent_q <= parent_mem[f_ff.node];
      sym_q    <= sym_mem[f_ff.node];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[f_ff.node] <= link_wdata;
      end
      link_q <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (tpat_we) begin
         tpat_mem[new_child] <= pcount_ff[amc_pkg::PAT_W-1:0];
      end
      tpat_q <= tpat_mem[u_ff];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[sp_ff] <= f_ff;
      end
      stack_q <= stack_mem[stack_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      sym_in        = sym_ff;
      fin_in        = fin_ff;
      ncount_in     = ncount_ff;
      pcount_in     = pcount_ff;
      bnode_in      = bnode_ff;
      blen_in       = blen_ff;
      bfault_in     = bfault_ff;
      snode_in      = snode_ff;
      pos_in        = pos_ff;
      known_in      = known_ff;
      mark_in       = mark_ff;
      f_in          = f_ff;
      sp_in         = sp_ff;
      tgt_in        = tgt_ff;
      ret_in        = ret_ff;
      x_in          = x_ff;
      u_in          = u_ff;
      cnt_in        = cnt_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      clr_in        = clr_ff;

      child_raddr = {bnode_ff, sym_ff};
      child_we    = 1'b0;
      child_waddr = {bnode_ff, sym_ff};
      child_wdata = alloc_node;
      alloc_we    = 1'b0;
      link_raddr  = tgt_ff;
      link_we     = 1'b0;
      link_wdata  = '0;
      tpat_we     = 1'b0;
      plen_we     = 1'b0;
      stack_raddr = sp_ff - 1'b1;
      stack_we    = 1'b0;
      push        = '0;

      case (state_ff)
         amc_pkg::ST_CLEAR: begin
            child_we    = 1'b1;
            child_waddr = clr_ff;
            child_wdata = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = amc_pkg::ST_IDLE;
            end
         end
         amc_pkg::ST_IDLE: begin
            if (req_valid) begin
               sym_in = req_data.symbol;
               fin_in = req_data.pattern_end;
               if (req_data.action == amc_pkg::ACT_SCAN) begin
                  pos_in   = pos_ff + 1'b1;
                  x_in     = snode_ff;
                  state_in = amc_pkg::ST_S_RD;
               end else if (bfault_ff) begin
                  // rest of a dropped pattern
                  if (req_data.pattern_end) begin
                     bnode_in  = '0;
                     blen_in   = '0;
                     bfault_in = 1'b0;
                  end
               end else begin
                  state_in = amc_pkg::ST_B_RD;
               end
            end
         end
         amc_pkg::ST_B_RD: begin
            state_in = amc_pkg::ST_B_DEC;
         end
         amc_pkg::ST_B_DEC: begin
            if (child_q == '0 && ncount_ff[amc_pkg::NCNT_W-1]) begin
               if (out_free) begin
                  push.push                = 1'b1;
                  push.data.kind           = amc_pkg::KIND_NODE_FULL;
                  push.data.last           = 1'b1;
                  if (fin_ff) begin
                     bnode_in = '0;
                     blen_in  = '0;
                  end else begin
                     bfault_in = 1'b1;
                  end
                  state_in = amc_pkg::ST_IDLE;
               end
            end else if (!(fin_ff && slot_full && !out_free)) begin
               if (child_q == '0) begin
                  child_we  = 1'b1;
                  alloc_we  = 1'b1;
                  ncount_in = ncount_ff + 1'b1;
                  known_in  = '0;
               end
               bnode_in = new_child;
               blen_in  = len_next;
               if (fin_ff) begin
                  if (slot_full) begin
                     push.push      = 1'b1;
                     push.data.kind = amc_pkg::KIND_SLOT_FULL;
                     push.data.last = 1'b1;
                  end else begin
                     mark_in[new_child] = 1'b1;
                     tpat_we            = 1'b1;
                     plen_we            = 1'b1;
                     pcount_in          = pcount_ff + 1'b1;
                  end
                  bnode_in = '0;
                  blen_in  = '0;
               end
               state_in = amc_pkg::ST_IDLE;
            end
         end
         amc_pkg::ST_S_RD: begin
            child_raddr = {x_ff, sym_ff};
            state_in    = amc_pkg::ST_S_DEC;
         end
         amc_pkg::ST_S_DEC: begin
            if (child_q != '0 || x_ff == '0) begin
               snode_in = child_q;
               u_in     = child_q;
               cnt_in   = '0;
               state_in = amc_pkg::ST_M_TEST;
            end else begin
               tgt_in   = x_ff;
               ret_in   = amc_pkg::RET_SCAN;
               state_in = amc_pkg::ST_L_REQ;
            end
         end
         amc_pkg::ST_L_REQ: begin
            if (known_ff[tgt_ff]) begin
               state_in = amc_pkg::ST_L_DAT;
            end else begin
               f_in.node = tgt_ff;
               f_in.walk = 1'b0;
               f_in.cur  = tgt_ff;
               state_in  = amc_pkg::ST_E_EVAL;
            end
         end
         amc_pkg::ST_L_DAT: begin
            if (ret_ff == amc_pkg::RET_SCAN) begin
               x_in     = link_q;
               state_in = amc_pkg::ST_S_RD;
            end else begin
               u_in     = link_q;
               state_in = amc_pkg::ST_M_TEST;
            end
         end
         amc_pkg::ST_E_EVAL: begin
            if (known_ff[f_ff.node]) begin
               state_in = amc_pkg::ST_E_POP;
            end else if (f_ff.node == '0) begin
               link_we               = 1'b1;
               known_in[f_ff.node]   = 1'b1;
               state_in              = amc_pkg::ST_E_POP;
            end else if (!f_ff.walk) begin
               state_in = amc_pkg::ST_E_PAR;
            end else begin
               state_in = amc_pkg::ST_E_SYM;
            end
         end
         amc_pkg::ST_E_PAR: begin
            link_raddr = parent_q;
            if (parent_q == '0) begin
               link_we             = 1'b1;
               known_in[f_ff.node] = 1'b1;
               state_in            = amc_pkg::ST_E_POP;
            end else if (!known_ff[parent_q]) begin
               // parent link first
               stack_we  = 1'b1;
               sp_in     = sp_ff + 1'b1;
               f_in.node = parent_q;
               f_in.walk = 1'b0;
               state_in  = amc_pkg::ST_E_EVAL;
            end else begin
               state_in = amc_pkg::ST_E_PLNK;
            end
         end
         amc_pkg::ST_E_PLNK: begin
            f_in.cur  = link_q;
            f_in.walk = 1'b1;
            state_in  = amc_pkg::ST_E_EVAL;
         end
         amc_pkg::ST_E_SYM: begin
            child_raddr = {f_ff.cur, sym_q};
            state_in    = amc_pkg::ST_E_CHD;
         end
         amc_pkg::ST_E_CHD: begin
            link_raddr = f_ff.cur;
            if (child_q != '0 || f_ff.cur == '0) begin
               link_we             = 1'b1;
               link_wdata          = child_q;
               known_in[f_ff.node] = 1'b1;
               state_in            = amc_pkg::ST_E_POP;
            end else if (known_ff[f_ff.cur]) begin
               state_in = amc_pkg::ST_E_XLNK;
            end else begin
               stack_we  = 1'b1;
               sp_in     = sp_ff + 1'b1;
               f_in.node = f_ff.cur;
               f_in.walk = 1'b0;
               state_in  = amc_pkg::ST_E_EVAL;
            end
         end
         amc_pkg::ST_E_XLNK: begin
            f_in.cur = link_q;
            state_in = amc_pkg::ST_E_EVAL;
         end
         amc_pkg::ST_E_POP: begin
            if (sp_ff == '0) begin
               state_in = amc_pkg::ST_L_REQ;
            end else begin
               sp_in    = sp_ff - 1'b1;
               state_in = amc_pkg::ST_E_RES;
            end
         end
         amc_pkg::ST_E_RES: begin
            f_in     = stack_q;
            state_in = amc_pkg::ST_E_EVAL;
         end
         amc_pkg::ST_M_TEST: begin
            if (u_ff == '0 || cnt_ff == amc_pkg::RCNT_W'(amc_pkg::RESULT_CAP)) begin
               state_in = amc_pkg::ST_M_END;
            end else if (mark_ff[u_ff]) begin
               state_in = amc_pkg::ST_M_PAT;
            end else begin
               tgt_in   = u_ff;
               ret_in   = amc_pkg::RET_MATCH;
               state_in = amc_pkg::ST_L_REQ;
            end
         end
         amc_pkg::ST_M_PAT: begin
            // the previous match goes out once a later one is known
            if (!held_valid_ff || out_free) begin
               push.push     = held_valid_ff;
               push.data     = held_ff;
               held_in       = match_rsp;
               held_valid_in = 1'b1;
               cnt_in        = cnt_ff + 1'b1;
               tgt_in        = u_ff;
               ret_in        = amc_pkg::RET_MATCH;
               state_in      = amc_pkg::ST_L_REQ;
            end
         end
         amc_pkg::ST_M_END: begin
            if (!held_valid_ff) begin
               state_in = amc_pkg::ST_IDLE;
            end else if (out_free) begin
               push.push      = 1'b1;
               push.data      = held_ff;
               push.data.last = 1'b1;
               held_valid_in  = 1'b0;
               state_in       = amc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = amc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/amc_rsp_reg.sv =====
// amc_rsp_reg: result output register between the sequencer and the rsp channel
// depends on amc_pkg
module amc_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  amc_pkg::push_type push,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output amc_pkg::rsp_type  rsp_data
);

   logic             valid_ff, valid_in;
   amc_pkg::rsp_type data_ff, data_in;

   assign out_free  = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (push.push) begin
         valid_in = 1'b1;
         data_in  = push.data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

// ===== src/multi_pattern_string_matcher.sv =====
// channel | direction | payload           | beat taken when
// req     | in        | amc_pkg::req_type | req_valid && !req_stall
// rsp     | out       | amc_pkg::rsp_type | rsp_valid && !rsp_stall
//
// a pattern symbol: accept, child-table read, update; only accept if its pattern is dropped
// a text symbol: accept, goto probe, chain test and end; each failed probe adds a link
// lookup and a new probe, each suffix-chain node a lookup and a test, each match a report
// links not yet cached cost a stack-driven walk through the trie memories
// after reset all 16384 child-table entries are cleared with req_stall high
// a stalled rsp beat holds the sequencer only when a further result is ready
module multi_pattern_string_matcher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  amc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output amc_pkg::rsp_type rsp_data
);

   logic              ready;
   logic              out_free;
   amc_pkg::push_type push;

   assign req_stall = !ready;

   amc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .ready     (ready),
      .out_free  (out_free),
      .push      (push)
   );

   amc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != amc_pkg::KIND_MATCH |->
         rsp_data.last && rsp_data.pattern_number == '0)
      else $error("error result not single");

   a_match_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == amc_pkg::KIND_MATCH |-> rsp_data.pattern_number != '0)
      else $error("match without pattern number");

   a_clear_busy: assert property (@(posedge clock) $past(reset) |-> req_stall)
      else $error("input taken during clearing");

endmodule
